// File: src/ccot_pkg.sv
// Shared widths and types for the circle versus capsule overlap pipeline.
package ccot_pkg;

    localparam int COORD_W = 24;              // signed Q15.8 coordinate
    localparam int RAD_W   = 23;              // unsigned Q15.8 radius
    localparam int DIFF_W  = COORD_W + 1;     // coordinate difference
    localparam int RS_W    = RAD_W + 1;       // sum of radii
    localparam int PROD_W  = 2 * DIFF_W;      // product of two differences
    localparam int DOT_W   = PROD_W + 1;      // signed dot product
    localparam int R2_W    = 2 * RS_W;        // squared radius sum
    localparam int HALF_W  = PROD_W / 2;      // partial product operand
    localparam int WIDE_W  = 2 * PROD_W;      // full wide product

    typedef struct packed {
        logic signed [DOT_W-1:0] num;   // d.w
        logic [PROD_W-1:0]       den;   // d.d
        logic [PROD_W-1:0]       w2;    // |c - s|^2
        logic [PROD_W-1:0]       q2;    // |c - e|^2
        logic [R2_W-1:0]         r2;    // (rc + rk)^2
    } t_geom;

endpackage

// File: src/ccot_geom.sv
// Differences, squares and dot products: three register stages.
module ccot_geom
    import ccot_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_circle_x,
    input  logic signed [COORD_W-1:0] i_circle_y,
    input  logic [RAD_W-1:0]          i_circle_radius,
    input  logic signed [COORD_W-1:0] i_seg_start_x,
    input  logic signed [COORD_W-1:0] i_seg_start_y,
    input  logic signed [COORD_W-1:0] i_seg_end_x,
    input  logic signed [COORD_W-1:0] i_seg_end_y,
    input  logic [RAD_W-1:0]          i_capsule_radius,
    output logic                      o_valid,
    output t_geom                     o_geom
);

    // stage 1
    logic signed [DIFF_W-1:0] n_dx, n_dy, n_wx, n_wy, n_qx, n_qy;
    logic [RS_W-1:0]          n_rs;
    logic signed [DIFF_W-1:0] r_dx, r_dy, r_wx, r_wy, r_qx, r_qy;
    logic [RS_W-1:0]          r_rs;
    logic                     r_v1;

    // stage 2
    logic signed [PROD_W-1:0] r_dxwx, r_dywy, r_dxdx, r_dydy;
    logic signed [PROD_W-1:0] r_wxwx, r_wywy, r_qxqx, r_qyqy;
    logic [R2_W-1:0]          r_rs2;
    logic                     r_v2;

    // stage 3
    t_geom n_geom;
    t_geom r_geom;
    logic  r_v3;

    always_comb begin
        n_dx = $signed({i_seg_end_x[COORD_W-1], i_seg_end_x})
             - $signed({i_seg_start_x[COORD_W-1], i_seg_start_x});
        n_dy = $signed({i_seg_end_y[COORD_W-1], i_seg_end_y})
             - $signed({i_seg_start_y[COORD_W-1], i_seg_start_y});
        n_wx = $signed({i_circle_x[COORD_W-1], i_circle_x})
             - $signed({i_seg_start_x[COORD_W-1], i_seg_start_x});
        n_wy = $signed({i_circle_y[COORD_W-1], i_circle_y})
             - $signed({i_seg_start_y[COORD_W-1], i_seg_start_y});
        n_qx = $signed({i_circle_x[COORD_W-1], i_circle_x})
             - $signed({i_seg_end_x[COORD_W-1], i_seg_end_x});
        n_qy = $signed({i_circle_y[COORD_W-1], i_circle_y})
             - $signed({i_seg_end_y[COORD_W-1], i_seg_end_y});
        n_rs = {1'b0, i_circle_radius} + {1'b0, i_capsule_radius};
    end

    // squares are never negative and stay below 2^49
    always_comb begin
        n_geom.num = $signed({r_dxwx[PROD_W-1], r_dxwx})
                   + $signed({r_dywy[PROD_W-1], r_dywy});
        n_geom.den = {1'b0, r_dxdx[PROD_W-2:0]} + {1'b0, r_dydy[PROD_W-2:0]};
        n_geom.w2  = {1'b0, r_wxwx[PROD_W-2:0]} + {1'b0, r_wywy[PROD_W-2:0]};
        n_geom.q2  = {1'b0, r_qxqx[PROD_W-2:0]} + {1'b0, r_qyqy[PROD_W-2:0]};
        n_geom.r2  = r_rs2;
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= n_dx;
        r_dy   <= n_dy;
        r_wx   <= n_wx;
        r_wy   <= n_wy;
        r_qx   <= n_qx;
        r_qy   <= n_qy;
        r_rs   <= n_rs;

        r_dxwx <= r_dx * r_wx;
        r_dywy <= r_dy * r_wy;
        r_dxdx <= r_dx * r_dx;
        r_dydy <= r_dy * r_dy;
        r_wxwx <= r_wx * r_wx;
        r_wywy <= r_wy * r_wy;
        r_qxqx <= r_qx * r_qx;
        r_qyqy <= r_qy * r_qy;
        r_rs2  <= r_rs * r_rs;

        r_geom <= n_geom;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_geom  = r_geom;

endmodule

// File: src/ccot_wmul.sv
// Two-stage unsigned wide multiplier built from four half-width partial products.
module ccot_wmul
    import ccot_pkg::*;
(
    input  logic              i_clk,
    input  logic [PROD_W-1:0] i_a,
    input  logic [PROD_W-1:0] i_b,
    output logic [WIDE_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [PROD_W:0]   n_mid;
    logic [WIDE_W-1:0] n_prod;
    logic [WIDE_W-1:0] r_prod;

    always_comb begin
        n_mid  = {1'b0, r_p01} + {1'b0, r_p10};
        // p11 and p00 do not overlap, so they concatenate
        n_prod = {r_p11, r_p00}
               + {{(WIDE_W - PROD_W - 1 - HALF_W){1'b0}}, n_mid, {HALF_W{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        r_p00  <= i_a[HALF_W-1:0]      * i_b[HALF_W-1:0];
        r_p01  <= i_a[HALF_W-1:0]      * i_b[PROD_W-1:HALF_W];
        r_p10  <= i_a[PROD_W-1:HALF_W] * i_b[HALF_W-1:0];
        r_p11  <= i_a[PROD_W-1:HALF_W] * i_b[PROD_W-1:HALF_W];
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

// File: src/ccot_decide.sv
// Clamp classification, exact wide interior test and final hit register.
module ccot_decide
    import ccot_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_geom i_geom,
    output logic  o_valid,
    output logic  o_hit
);

    logic              n_at_start, n_at_end, n_mid, n_simple;
    logic [PROD_W-1:0] r2_ext, num_mag;
    logic [WIDE_W-1:0] lhs_prod, r2den_prod, numsq_prod;

    logic              r_mid4, r_simple4, r_v4;
    logic              r_mid5, r_simple5, r_v5;
    logic [WIDE_W-1:0] n_rhs;
    logic [WIDE_W-1:0] r_lhs6, r_rhs6;
    logic              r_mid6, r_simple6, r_v6;
    logic              n_hit;
    logic              r_hit, r_v7;

    always_comb begin
        r2_ext     = {{(PROD_W - R2_W){1'b0}}, i_geom.r2};
        n_at_start = i_geom.num[DOT_W-1] || (i_geom.num == '0);
        n_at_end   = i_geom.num >= $signed({1'b0, i_geom.den});
        n_mid      = !n_at_start && !n_at_end;
        n_simple   = n_at_start ? (i_geom.w2 < r2_ext) : (i_geom.q2 < r2_ext);
        // only used in the interior case, where 0 < num < den < 2^50
        num_mag    = i_geom.num[PROD_W-1:0];
    end

    ccot_wmul u_lhs (
        .i_clk  (i_clk),
        .i_a    (i_geom.w2),
        .i_b    (i_geom.den),
        .o_prod (lhs_prod)
    );

    ccot_wmul u_r2den (
        .i_clk  (i_clk),
        .i_a    (r2_ext),
        .i_b    (i_geom.den),
        .o_prod (r2den_prod)
    );

    ccot_wmul u_numsq (
        .i_clk  (i_clk),
        .i_a    (num_mag),
        .i_b    (num_mag),
        .o_prod (numsq_prod)
    );

    // rhs never exceeds 2^99, no carry out
    assign n_rhs = r2den_prod + numsq_prod;
    assign n_hit = r_mid6 ? (r_lhs6 < r_rhs6) : r_simple6;

    always_ff @(posedge i_clk) begin
        r_mid4    <= n_mid;
        r_simple4 <= n_simple;
        r_mid5    <= r_mid4;
        r_simple5 <= r_simple4;
        r_mid6    <= r_mid5;
        r_simple6 <= r_simple5;
        r_lhs6    <= lhs_prod;
        r_rhs6    <= n_rhs;
        r_hit     <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign o_valid = r_v7;
    assign o_hit   = r_hit;

endmodule

// File: src/circle_capsule_overlap_test_top.sv
// Circle versus capsule overlap test: top level with port handshake and checks.
//
// One circle/capsule pair is taken per transaction (start high while busy is low) and
// its answer appears on o_hit with o_valid high for one cycle at the pipeline's end.
// busy is never raised: a new pair may be started in every cycle, so throughput is one
// pair per clock. The latency comes from a 7-stage pipeline: differences, 25x25 squares
// and dot products, sums, clamp classification with 25x25 partial products, assembly of
// the 100-bit products, the right-hand sum, and the final compare. The result cannot be
// held off; it must be taken in the cycle it is shown.
module circle_capsule_overlap_test_top
    import ccot_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [COORD_W-1:0] i_circle_x,
    input  logic signed [COORD_W-1:0] i_circle_y,
    input  logic [RAD_W-1:0]          i_circle_radius,
    input  logic signed [COORD_W-1:0] i_seg_start_x,
    input  logic signed [COORD_W-1:0] i_seg_start_y,
    input  logic signed [COORD_W-1:0] i_seg_end_x,
    input  logic signed [COORD_W-1:0] i_seg_end_y,
    input  logic [RAD_W-1:0]          i_capsule_radius,
    output logic                      o_valid,
    output logic                      o_hit
);

    logic  accept;
    logic  geom_valid;
    t_geom geom;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ccot_geom u_geom (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (accept),
        .i_circle_x       (i_circle_x),
        .i_circle_y       (i_circle_y),
        .i_circle_radius  (i_circle_radius),
        .i_seg_start_x    (i_seg_start_x),
        .i_seg_start_y    (i_seg_start_y),
        .i_seg_end_x      (i_seg_end_x),
        .i_seg_end_y      (i_seg_end_y),
        .i_capsule_radius (i_capsule_radius),
        .o_valid          (geom_valid),
        .o_geom           (geom)
    );

    ccot_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_valid),
        .i_geom  (geom),
        .o_valid (o_valid),
        .o_hit   (o_hit)
    );

`ifndef SYNTHESIS
    // every transaction yields exactly one result
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##7 o_valid)
        else $error("result missing for accepted transaction");

    a_latency_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, 7))
        else $error("result without a transaction");

    // with both radii zero no distance can be strictly below the sum
    a_zero_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_circle_radius == '0 && i_capsule_radius == '0) |-> ##7 !o_hit)
        else $error("hit reported with zero radii");
`endif

endmodule
